// ===== rtl/core/dls_pkg.sv =====
package dls_pkg;

  localparam int MAX_TASKS  = 32;
  localparam int SLOT_COUNT = (MAX_TASKS < 32) ? MAX_TASKS : 32;
  localparam int SLOT_AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SCAN_CW    = $clog2(SLOT_COUNT + 1);

  localparam int DEP_W    = 32;
  localparam int TASK_W   = 5;
  localparam int LEVEL_W  = 5;
  localparam int STATUS_W = 2;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_COMPUTE = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_PLACED = 2'd0,
    STATUS_CYCLE  = 2'd1,
    STATUS_EMPTY  = 2'd2
  } status_t;

endpackage

// ===== rtl/core/dls_if.sv =====
interface dls_cmd_if
  import dls_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [TASK_W-1:0] task_index;
  logic              in_use;
  logic [DEP_W-1:0]  depends_on;

  modport source (output valid, opcode, task_index, in_use, depends_on, input ready);
  modport sink   (input valid, opcode, task_index, in_use, depends_on, output ready);
endinterface

interface dls_res_if
  import dls_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [LEVEL_W-1:0]  level;
  logic [TASK_W-1:0]   task_id;
  logic                last;

  modport source (output valid, status, level, task_id, last, input ready);
  modport sink   (input valid, status, level, task_id, last, output ready);
endinterface

// ===== rtl/core/dependency_level_scheduler_unit.sv =====
// Dependency level scheduler. A load word writes one task slot (used flag and
// dependency mask). A compute word groups the used tasks into levels and
// returns one word per placed task, level by level and in ascending slot
// order, the final word marked last; a dependency cycle ends the run with a
// cycle status word, and an empty table gives one empty status word. The
// dependency masks live in a single RAM with one read port, so each level
// costs a full sweep of all slots through that port before its tasks are
// emitted, and output stalls can hold the run. The table needs no clearing
// pass after reset; only the masks of slots loaded as used are judged.
module dependency_level_scheduler_unit
  import dls_pkg::*;
(
  input logic    clk,
  input logic    rst,
  dls_cmd_if.sink   cmd,
  dls_res_if.source res
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMPTY,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  function automatic logic [SLOT_AW-1:0] low_index(input logic [SLOT_COUNT-1:0] v);
    logic [SLOT_COUNT-1:0] one;
    logic [SLOT_AW-1:0]    idx;
    one = v & (~v + SLOT_COUNT'(1));
    idx = '0;
    for (int j = 0; j < SLOT_COUNT; j++) begin
      if (one[j]) idx = idx | SLOT_AW'(j);
    end
    return idx;
  endfunction

  state_t                state;
  logic [SLOT_COUNT-1:0] used;
  logic [SLOT_COUNT-1:0] placed;
  logic [SLOT_COUNT-1:0] chosen;
  logic [LEVEL_W-1:0]    level_cnt;
  logic [SCAN_CW-1:0]    scan_cnt;
  logic                  is_final;

  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic [LEVEL_W-1:0]    out_level;
  logic [TASK_W-1:0]     out_task;
  logic                  out_last;

  logic                  cmd_fire;
  logic                  load_we;
  logic [DEP_W-1:0]      rd_data;
  logic [SLOT_AW-1:0]    eval_idx;
  logic [SLOT_COUNT-1:0] pending;
  logic                  eval_ok;
  logic                  out_free;
  logic                  out_set;
  logic [SLOT_COUNT-1:0] chosen_rest;
  logic [SLOT_AW-1:0]    emit_idx;

  assign cmd.ready = (state == ST_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign load_we   = cmd_fire && (cmd.opcode == OP_LOAD) && (32'(cmd.task_index) < SLOT_COUNT);

  dls_ram #(
    .WIDTH(DEP_W),
    .DEPTH(SLOT_COUNT)
  ) u_dep_ram (
    .clk  (clk),
    .we   (load_we),
    .waddr(cmd.task_index[SLOT_AW-1:0]),
    .wdata(cmd.depends_on),
    .raddr(scan_cnt[SLOT_AW-1:0]),
    .rdata(rd_data)
  );

  // slot k is read while scan_cnt == k and judged in the next cycle, while scan_cnt == k + 1
  assign eval_idx    = SLOT_AW'(scan_cnt - SCAN_CW'(1));
  assign pending     = used & ~placed;
  assign eval_ok     = used[eval_idx] && !placed[eval_idx]
                       && ((rd_data[SLOT_COUNT-1:0] & pending) == '0);
  assign out_free    = !out_valid || res.ready;
  assign out_set     = out_free && ((state == ST_EMPTY) || (state == ST_EMIT)
                       || ((state == ST_DECIDE) && (chosen == '0)));
  assign chosen_rest = chosen & (chosen - SLOT_COUNT'(1));
  assign emit_idx    = low_index(chosen);

  assign res.valid   = out_valid;
  assign res.status  = out_status;
  assign res.level   = out_level;
  assign res.task_id = out_task;
  assign res.last    = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      used      <= '0;
      placed    <= '0;
      chosen    <= '0;
      level_cnt <= '0;
      scan_cnt  <= '0;
      is_final  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_set || (out_valid && !res.ready);

      unique case (state)
        ST_IDLE: begin
          if (load_we) begin
            used[cmd.task_index[SLOT_AW-1:0]] <= cmd.in_use;
          end
          if (cmd_fire && cmd.opcode == OP_COMPUTE) begin
            placed    <= '0;
            chosen    <= '0;
            level_cnt <= '0;
            scan_cnt  <= '0;
            state     <= (used == '0) ? ST_EMPTY : ST_SCAN;
          end
        end

        ST_EMPTY: begin
          if (out_free) begin
            out_status <= STATUS_EMPTY;
            out_level  <= '0;
            out_task   <= '0;
            out_last   <= 1'b1;
            state      <= ST_IDLE;
          end
        end

        ST_SCAN: begin
          if (scan_cnt != '0) begin
            chosen[eval_idx] <= eval_ok;
          end
          if (scan_cnt == SCAN_CW'(SLOT_COUNT)) begin
            state <= ST_DECIDE;
          end else begin
            scan_cnt <= scan_cnt + SCAN_CW'(1);
          end
        end

        ST_DECIDE: begin
          if (chosen == '0) begin
            // nothing ready but tasks remain: dependency cycle
            if (out_free) begin
              out_status <= STATUS_CYCLE;
              out_level  <= level_cnt;
              out_task   <= TASK_W'(low_index(pending));
              out_last   <= 1'b1;
              state      <= ST_IDLE;
            end
          end else begin
            is_final <= ((placed | chosen) == used);
            state    <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          if (out_free) begin
            out_status <= STATUS_PLACED;
            out_level  <= level_cnt;
            out_task   <= TASK_W'(emit_idx);
            out_last   <= is_final && (chosen_rest == '0);
            placed     <= placed | (chosen & ~chosen_rest);
            chosen     <= chosen_rest;
            if (chosen_rest == '0) begin
              level_cnt <= level_cnt + LEVEL_W'(1);
              scan_cnt  <= '0;
              state     <= is_final ? ST_IDLE : ST_SCAN;
            end
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  a_placed_used: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> ((placed & ~used) == '0))
    else $error("placed task outside used slots");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (chosen != '0))
    else $error("emit with empty level");

  a_chosen_fresh: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> ((chosen & placed) == '0))
    else $error("task chosen twice");

  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && scan_cnt == '0) |-> (chosen == '0))
    else $error("level scan starts with stale selection");

endmodule

// ===== rtl/core/dls_ram.sv =====
module dls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import dls_pkg::*;

  localparam int IDLE_LIMIT  = 8000;
  localparam int TAIL_CYCLES = 200;
  localparam int PHASE_WORDS = 45;
  localparam logic [31:0] SLOT_RANGE =
    (SLOT_COUNT >= 32) ? 32'hFFFF_FFFF : ((32'h1 << SLOT_COUNT) - 32'h1);

  typedef struct packed {
    opcode_t           opcode;
    logic [TASK_W-1:0] task_index;
    logic              in_use;
    logic [DEP_W-1:0]  depends_on;
  } cmd_word_t;

  typedef struct packed {
    status_t            status;
    logic [LEVEL_W-1:0] level;
    logic [TASK_W-1:0]  task_id;
    logic               last;
  } sched_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dls_cmd_if cmd_if ();
  dls_res_if res_if ();

  dependency_level_scheduler_unit i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if)
  );

  always #2 clk = ~clk;

  cmd_word_t   cmd_pending[$];
  sched_word_t schedule_q[$];

  // predictor copy of the slot table
  logic [31:0]      tbl_used;
  logic [DEP_W-1:0] tbl_dep [32];
  // stimulus-side view of which slots are used
  logic [31:0]      gen_used;

  cmd_word_t   acc_w;
  sched_word_t exp_w;

  int send_idle      = 0;
  int recv_stall     = 0;
  int words_queued   = 0;
  int words_accepted = 0;
  int computes_seen  = 0;
  int results_seen   = 0;
  int errors         = 0;
  int idle_cycles    = 0;

  task automatic predict_schedule(input cmd_word_t w);
    logic [31:0] used, placed, done, chosen, stuck;
    logic [LEVEL_W-1:0] lvl;
    logic cycle;
    int low;
    sched_word_t r;
    sched_word_t run[$];
    if (w.opcode == OP_LOAD) begin
      if (w.task_index < SLOT_COUNT) begin
        tbl_used[w.task_index] = w.in_use;
        tbl_dep[w.task_index]  = w.depends_on;
      end
      return;
    end
    used     = tbl_used & SLOT_RANGE;
    tbl_used = used;
    if (used == '0) begin
      r.status  = STATUS_EMPTY;
      r.level   = '0;
      r.task_id = '0;
      r.last    = 1'b1;
      schedule_q = {schedule_q, r};
      return;
    end
    placed = '0;
    lvl    = '0;
    cycle  = 1'b0;
    while (!cycle && ((placed & used) != used)) begin
      // tasks that become ready inside a level only count from the next one
      done   = ~used | placed | ~SLOT_RANGE;
      chosen = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (used[i] && !placed[i] && ((tbl_dep[i] & SLOT_RANGE & ~done) == '0))
          chosen[i] = 1'b1;
      end
      if (chosen == '0) begin
        stuck = used & ~placed;
        low   = 0;
        while (low < 31 && !stuck[low]) low++;
        r.status  = STATUS_CYCLE;
        r.level   = lvl;
        r.task_id = TASK_W'(low);
        r.last    = 1'b1;
        run = {run, r};
        cycle = 1'b1;
      end else begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (chosen[i]) begin
            r.status  = STATUS_PLACED;
            r.level   = lvl;
            r.task_id = TASK_W'(i);
            r.last    = 1'b0;
            run = {run, r};
          end
        end
        placed = placed | chosen;
        lvl    = lvl + 1'b1;
      end
    end
    if (!cycle) run[run.size() - 1].last = 1'b1;
    schedule_q = {schedule_q, run};
  endtask

  task automatic push_load(input int idx, input logic occupied, input logic [31:0] deps);
    cmd_word_t w;
    w.opcode     = OP_LOAD;
    w.task_index = TASK_W'(idx);
    w.in_use     = occupied;
    w.depends_on = deps;
    cmd_pending = {cmd_pending, w};
    words_queued++;
    gen_used[idx] = occupied;
  endtask

  task automatic push_compute();
    cmd_word_t w;
    w.opcode     = OP_COMPUTE;
    w.task_index = TASK_W'($urandom());
    w.in_use     = 1'($urandom_range(0, 1));
    w.depends_on = $urandom();
    cmd_pending = {cmd_pending, w};
    words_queued++;
  endtask

  task automatic wait_drained();
    while (words_accepted != words_queued || schedule_q.size() != 0) @(negedge clk);
  endtask

  // a few loads, mostly acyclic, then a compute, sometimes two
  task automatic push_scenario();
    int k, idx, r;
    logic [31:0] lower, deps;
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, 4)) push_load($urandom_range(0, 31), 1'b0, $urandom());
    end
    k = $urandom_range(1, 6);
    repeat (k) begin
      idx   = $urandom_range(0, 31);
      lower = (32'h1 << idx) - 32'h1;
      r     = $urandom_range(0, 99);
      if (r < 70) begin
        deps = ($urandom() & $urandom() & lower) |
               ($urandom() & ~gen_used & ~(32'h1 << idx));
      end else if (r < 85) begin
        // back edge onto a used slot at or above this one
        deps = ($urandom() & lower) | ($urandom() & gen_used & ~lower);
        if ((deps & ~lower) == '0) deps = deps | (32'h1 << idx);
      end else begin
        deps = $urandom();
      end
      push_load(idx, 1'($urandom_range(0, 9) != 0), deps);
    end
    push_compute();
    if ($urandom_range(0, 9) == 0) push_compute();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cmd_if.valid <= 1'b0;
    end else if (!cmd_if.valid || cmd_if.ready) begin
      if (cmd_pending.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        cmd_if.valid      <= 1'b1;
        cmd_if.opcode     <= cmd_pending[0].opcode;
        cmd_if.task_index <= cmd_pending[0].task_index;
        cmd_if.in_use     <= cmd_pending[0].in_use;
        cmd_if.depends_on <= cmd_pending[0].depends_on;
        void'(cmd_pending.pop_front());
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (schedule_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word status=%0d level=%0d task=%0d last=%0d",
                   $time, res_if.status, res_if.level, res_if.task_id, res_if.last);
        end else begin
          exp_w = schedule_q.pop_front();
          if (res_if.status !== exp_w.status || res_if.level !== exp_w.level ||
              res_if.task_id !== exp_w.task_id || res_if.last !== exp_w.last) begin
            errors++;
            $display("%0t: mismatch expected status=%0d level=%0d task=%0d last=%0d",
                     $time, exp_w.status, exp_w.level, exp_w.task_id, exp_w.last);
            $display("%0t:          actual   status=%0d level=%0d task=%0d last=%0d",
                     $time, res_if.status, res_if.level, res_if.task_id, res_if.last);
          end
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        words_accepted++;
        if (cmd_if.opcode == OP_COMPUTE) computes_seen++;
        acc_w.opcode     = opcode_t'(cmd_if.opcode);
        acc_w.task_index = cmd_if.task_index;
        acc_w.in_use     = cmd_if.in_use;
        acc_w.depends_on = cmd_if.depends_on;
        predict_schedule(acc_w);
      end
    end
  end

  always @(posedge clk) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d result words outstanding",
               $time, IDLE_LIMIT, schedule_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int start;
    logic [31:0] deps;
    cmd_if.valid      = 1'b0;
    cmd_if.opcode     = 1'b0;
    cmd_if.task_index = '0;
    cmd_if.in_use     = 1'b0;
    cmd_if.depends_on = '0;
    res_if.ready      = 1'b0;
    tbl_used          = '0;
    gen_used          = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty table
    push_compute();
    // two levels, one task depending on an unused slot
    push_load(0, 1'b1, 32'h0000_0000);
    push_load(31, 1'b1, 32'h0000_0001);
    push_load(5, 1'b1, 32'h0000_0080);
    push_compute();
    // self dependency blocks slot 5 through slot 7
    push_load(7, 1'b1, 32'h0000_0080);
    push_compute();
    push_load(7, 1'b1, 32'hFFFF_FFFF);
    push_compute();
    // clearing slot 7 frees slot 5 again, repeated compute gives the same run
    push_load(7, 1'b0, 32'hFFFF_FFFF);
    push_compute();
    push_compute();
    push_load(0, 1'b0, 32'h0000_0000);
    push_load(5, 1'b0, 32'h0000_0000);
    push_compute();
    // two-task cycle after one placed level
    push_load(1, 1'b1, 32'h0000_0004);
    push_load(2, 1'b1, 32'h0000_0002);
    push_compute();
    push_load(1, 1'b0, 32'h0000_0000);
    push_load(2, 1'b0, 32'h0000_0000);
    push_load(31, 1'b0, 32'h7FFF_FFFF);
    push_compute();
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 47; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 47; end
        default: begin send_idle = 22; recv_stall = 22; end
      endcase
      start = words_queued;
      if (ph == 0) begin
        // every slot in level zero
        for (int i = 0; i < 32; i++) push_load(i, 1'b1, 32'h0000_0000);
        push_compute();
      end else if (ph == 2) begin
        // full-depth chain, one task per level
        for (int i = 0; i < 32; i++) begin
          deps = (i == 0) ? 32'h0 :
                 ((32'h1 << (i - 1)) | ($urandom() & ((32'h1 << (i - 1)) - 32'h1)));
          push_load(i, 1'b1, deps);
        end
        push_compute();
      end
      while (words_queued - start < PHASE_WORDS) push_scenario();
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Run covered %0d command words with %0d computes and %0d result words,",
             words_accepted, computes_seen, results_seen);
    $display("over phases with no idling, sender gaps, receiver stalls and both.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
